### rtl/core/dac_waveform_pair_generator_core_assert.svh
// Assertion macros shared by the waveform pair generator queue and datapath modules.
`ifndef DAC_WAVEFORM_PAIR_GENERATOR_CORE_ASSERT_SVH
`define DAC_WAVEFORM_PAIR_GENERATOR_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define DWPG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DWPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Free-form property body.
`define DWPG_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

### rtl/core/dwpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpg_pkg
// Shared types, register indexes and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package dwpg_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_WAVE_MODE   = 2'd0;
   localparam logic [1:0] CSR_AMPLITUDE   = 2'd1;
   localparam logic [1:0] CSR_PERIOD_LOG2 = 2'd2;

   localparam logic [15:0] AMPLITUDE_RESET = 16'd4096;
   localparam logic [3:0]  PERIOD_RESET    = 4'd13;
   localparam logic [3:0]  PERIOD_MIN      = 4'd2;
   localparam logic [3:0]  PERIOD_MAX      = 4'd13;

   localparam int TABLE_WORDS_DEFAULT = 4096;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 2;

   // Quarter-wave table: points 0..2048 of a 2^13 point grid, Q18 values.
   localparam int QTR_POINTS = 2049;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   typedef logic [18:0] sin_rom_type [0:QTR_POINTS-1];

   // Live configuration as seen by the datapath.
   typedef struct packed {
      logic        ramp;
      logic [15:0] amp;
      logic [3:0]  k_eff;
   } dwpg_cfg_type;

   // One waveform point after classification.
   typedef struct packed {
      logic [11:0] addr;
      logic        neg;
      logic [12:0] m;
   } dwpg_point_type;

   // One queued table word.
   typedef struct packed {
      logic [11:0]    index;
      dwpg_point_type even;
      dwpg_point_type odd;
   } dwpg_entry_type;

   // Queue status toward the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } dwpg_queue_status_type;

   // Unsigned quotient by shift and subtract; only used while the table is built.
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sine of r*(pi/2)/2048 in Q18, Horner form of the Taylor series in Q30.
   function automatic logic [18:0] quarter_sin_q18(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] sub;
      logic [63:0] s;
      x  = (r * HALF_PI_Q30 + 64'd1024) >> 11;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 7; k >= 1; k--) begin
         d   = 64'((2 * k) * (2 * k + 1));
         sub = div_u64((x2 * t) >> 30, d);
         t   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      end
      s = (x * t) >> 30;
      s = (s + 64'd2048) >> 12;
      if (s > (64'd1 << 18)) begin
         s = 64'd1 << 18;
      end
      return s[18:0];
   endfunction

   // Builds the whole quarter-wave table at elaboration.
   function automatic sin_rom_type sin_rom_build();
      sin_rom_type rom;
      for (int i = 0; i < QTR_POINTS; i++) begin
         rom[i] = quarter_sin_q18(64'(i));
      end
      return rom;
   endfunction

endpackage

### rtl/core/dwpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpg_front
// Accepts word indexes, reduces them to the table and classifies both points.
// ----------------------------------------------------------------------------
module dwpg_front #(
   parameter int TABLE_WORDS = dwpg_pkg::TABLE_WORDS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [11:0]            word_index,
   input  dwpg_pkg::dwpg_cfg_type cfg,
   output logic                   push,
   output dwpg_pkg::dwpg_entry_type push_entry
);
   import dwpg_pkg::*;

   // Reciprocal for an exact quotient of any 12-bit index.
   localparam logic [24:0] RECIP = 25'((2 ** 24 + TABLE_WORDS - 1) / TABLE_WORDS);
   localparam logic [12:0] TW    = 13'(TABLE_WORDS);

   logic        v1_ff, v1_in;
   logic        v2_ff, v2_in;
   logic [11:0] raw_ff, raw_in;
   logic [11:0] quo_ff, quo_in;
   logic [11:0] w_ff, w_in;
   logic [36:0] quo_full;
   logic [24:0] quo_times;

   // Map one point of the period onto the quarter-wave grid.
   function automatic dwpg_point_type classify(input logic [11:0] w, input logic [3:0] k,
                                               input logic odd);
      dwpg_point_type pt;
      logic [12:0] n;
      logic [12:0] mask;
      logic [12:0] m;
      logic [12:0] p;
      n    = {w, odd};
      mask = ~(13'h1FFF << k);
      m    = n & mask;
      p    = m << (4'd13 - k);
      pt.m    = m;
      pt.neg  = p[12];
      pt.addr = p[11] ? (12'd2048 - {1'b0, p[10:0]}) : {1'b0, p[10:0]};
      return pt;
   endfunction

   // Stage one: capture the index and its quotient by the table size.
   assign quo_full = 37'(word_index) * 37'(RECIP);
   assign quo_in   = quo_full[35:24];
   assign raw_in   = word_index;
   assign v1_in    = accept;

   // Stage two: remainder.
   assign quo_times = 25'(quo_ff) * 25'(TW);
   assign w_in      = raw_ff - quo_times[11:0];
   assign v2_in     = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      raw_ff <= raw_in;
      quo_ff <= quo_in;
      w_ff   <= w_in;
   end

   // Classified word goes straight into the queue.
   assign push             = v2_ff;
   assign push_entry.index = w_ff;
   assign push_entry.even  = classify(w_ff, cfg.k_eff, 1'b0);
   assign push_entry.odd   = classify(w_ff, cfg.k_eff, 1'b1);

endmodule

### rtl/core/dwpg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpg_queue
// Short queue between the front end and the sample datapath.
// ----------------------------------------------------------------------------
`include "dac_waveform_pair_generator_core_assert.svh"
module dwpg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dwpg_pkg::dwpg_entry_type push_entry,
   input  logic                    pop,
   output dwpg_pkg::dwpg_entry_type pop_entry,
   output dwpg_pkg::dwpg_queue_status_type status
);
   import dwpg_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dwpg_entry_type mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_entry;
      end
   end

   assign pop_entry    = mem[rd_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));

   `DWPG_ASSERT_PROP(a_count_bound, clock, reset, (count_ff <= CW'(QUEUE_DEPTH)), "queue count over depth")
   `DWPG_ASSERT_IMPLIES(a_no_overflow, clock, reset, push && status.full, pop, "push into full queue")
   `DWPG_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise")

endmodule

### rtl/core/dwpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpg_back
// Sample datapath: sine table lookup, scaling by amplitude and saturation.
// ----------------------------------------------------------------------------
`include "dac_waveform_pair_generator_core_assert.svh"
module dwpg_back #(
   parameter int SAMPLE_BITS = dwpg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dwpg_pkg::dwpg_cfg_type  cfg,
   input  dwpg_pkg::dwpg_queue_status_type status,
   input  dwpg_pkg::dwpg_entry_type pop_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [11:0]             rsp_index_echo,
   output logic [SAMPLE_BITS-1:0]  rsp_even_sample,
   output logic [SAMPLE_BITS-1:0]  rsp_odd_sample
);
   import dwpg_pkg::*;

   localparam sin_rom_type SIN_ROM = sin_rom_build();
   localparam logic [35:0] CAP     = 36'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [19:0] ONE_Q18 = 20'd1 << 18;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   dwpg_entry_type         e1_ff;
   logic [18:0]            se_ff, so_ff;
   logic [11:0]            idx2_ff, idx3_ff, idx4_ff;
   logic [19:0]            ope_ff, ope_in, opo_ff, opo_in;
   logic [35:0]            pre_ff, pre_in, pro_ff, pro_in;
   logic [35:0]            she, sho;
   logic [SAMPLE_BITS-1:0] oute_ff, oute_in, outo_ff, outo_in;

   // Sine operand or ramp point, Q18 for sine.
   function automatic logic [19:0] operand(input logic ramp, input logic neg,
                                           input logic [12:0] m, input logic [18:0] s);
      logic [19:0] r;
      if (ramp) begin
         r = 20'(m);
      end else if (neg) begin
         r = ONE_Q18 - 20'(s);
      end else begin
         r = ONE_Q18 + 20'(s);
      end
      return r;
   endfunction

   assign pop = !status.empty;

   // Stage one: table reads for both points.
   always_ff @(posedge clock) begin
      se_ff <= SIN_ROM[pop_entry.even.addr];
      so_ff <= SIN_ROM[pop_entry.odd.addr];
      e1_ff <= pop_entry;
   end

   // Stage two: operand, stage three: product, stage four: scale and saturate.
   assign ope_in = operand(cfg.ramp, e1_ff.even.neg, e1_ff.even.m, se_ff);
   assign opo_in = operand(cfg.ramp, e1_ff.odd.neg, e1_ff.odd.m, so_ff);
   assign pre_in = 36'(ope_ff) * 36'(cfg.amp);
   assign pro_in = 36'(opo_ff) * 36'(cfg.amp);
   assign she    = cfg.ramp ? (pre_ff >> cfg.k_eff) : (pre_ff >> 19);
   assign sho    = cfg.ramp ? (pro_ff >> cfg.k_eff) : (pro_ff >> 19);
   assign oute_in = (she > CAP) ? CAP[SAMPLE_BITS-1:0] : she[SAMPLE_BITS-1:0];
   assign outo_in = (sho > CAP) ? CAP[SAMPLE_BITS-1:0] : sho[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      ope_ff  <= ope_in;
      opo_ff  <= opo_in;
      idx2_ff <= e1_ff.index;
      pre_ff  <= pre_in;
      pro_ff  <= pro_in;
      idx3_ff <= idx2_ff;
      oute_ff <= oute_in;
      outo_ff <= outo_in;
      idx4_ff <= idx3_ff;
   end

   assign rsp_valid       = v4_ff;
   assign rsp_index_echo  = idx4_ff;
   assign rsp_even_sample = oute_ff;
   assign rsp_odd_sample  = outo_ff;

   `DWPG_ASSERT_PROP(a_pop_to_rsp, clock, reset, (pop |-> ##4 rsp_valid), "popped word gave no result")
   `DWPG_ASSERT_IMPLIES(a_rsp_from_pop, clock, reset, rsp_valid, $past(pop, 4), "result without popped word")
   `DWPG_ASSERT_IMPLIES(a_sine_range, clock, reset, v2_ff && !cfg.ramp, (ope_ff <= (ONE_Q18 << 1)) && (opo_ff <= (ONE_Q18 << 1)), "sine operand out of range")

endmodule

### rtl/core/dac_waveform_pair_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_waveform_pair_generator_core
// Produces two DAC samples (sine or ramp) for each table word index.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfer: drive req_word_index and raise start; the word is taken
//   at a rising edge where start is high and busy is low. busy stays low in
//   normal operation, so one word can be taken on every clock.
//   Result transfer: rsp_valid is high for one cycle with rsp_index_echo,
//   rsp_even_sample (point 2w) and rsp_odd_sample (point 2w+1). The receiver
//   cannot stall; results leave in input order.
//   From the accepting edge to the edge that takes the result, a word passes
//   two front stages (quotient, remainder with point classification), one
//   queue slot, and four datapath stages (sine table read, operand, amplitude
//   multiply, scale and saturate). Throughput is one word per cycle while busy
//   is low, set by the dual-read sine table and the two amplitude multipliers.
//   Configuration: csr_valid/csr_ready with csr_index and csr_wdata; csr_ready
//   is always high. Write only while no word is in flight.
//   Reset: synchronous; registers return to sine mode, amplitude 4096, period
//   log2 13, and the pipeline empties.
module dac_waveform_pair_generator_core #(
   parameter int TABLE_WORDS = dwpg_pkg::TABLE_WORDS_DEFAULT,
   parameter int SAMPLE_BITS = dwpg_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [11:0]            req_word_index,
   output logic                   rsp_valid,
   output logic [11:0]            rsp_index_echo,
   output logic [SAMPLE_BITS-1:0] rsp_even_sample,
   output logic [SAMPLE_BITS-1:0] rsp_odd_sample,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   import dwpg_pkg::*;

   logic                  mode_ff, mode_in;
   logic [15:0]           amp_ff, amp_in;
   logic [3:0]            plog_ff, plog_in;
   logic                  csr_write;
   dwpg_cfg_type          cfg;
   logic                  push;
   logic                  pop;
   dwpg_entry_type        push_entry;
   dwpg_entry_type        pop_entry;
   dwpg_queue_status_type status;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      mode_in = mode_ff;
      amp_in  = amp_ff;
      plog_in = plog_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WAVE_MODE:   mode_in = csr_wdata[0];
            CSR_AMPLITUDE:   amp_in  = csr_wdata;
            CSR_PERIOD_LOG2: plog_in = csr_wdata[3:0];
            default:         mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         amp_ff  <= AMPLITUDE_RESET;
         plog_ff <= PERIOD_RESET;
      end else begin
         mode_ff <= mode_in;
         amp_ff  <= amp_in;
         plog_ff <= plog_in;
      end
   end

   // Effective period clamped to the supported range.
   assign cfg.ramp  = mode_ff;
   assign cfg.amp   = amp_ff;
   assign cfg.k_eff = (plog_ff < PERIOD_MIN) ? PERIOD_MIN :
                      (plog_ff > PERIOD_MAX) ? PERIOD_MAX : plog_ff;

   assign busy = status.full;

   dwpg_front #(
      .TABLE_WORDS(TABLE_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .word_index(req_word_index),
      .cfg       (cfg),
      .push      (push),
      .push_entry(push_entry)
   );

   dwpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .pop_entry (pop_entry),
      .status    (status)
   );

   dwpg_back #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .status         (status),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_index_echo (rsp_index_echo),
      .rsp_even_sample(rsp_even_sample),
      .rsp_odd_sample (rsp_odd_sample)
   );

endmodule

### verif/dac_waveform_pair_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_waveform_pair_generator_core_tb
// Drives table word indexes through the generator under several register
// settings and checks every returned sample pair against a local predictor or typed-in values.
// ----------------------------------------------------------------------------
module dac_waveform_pair_generator_core_tb;
   import dwpg_pkg::*;

   localparam int LATENCY   = 7;
   localparam int CYCLE_CAP = 400000;

   // Directed stimulus row; a nonzero check flag means the expected pair is typed in.
   typedef struct {
      logic [11:0] word;
      logic        check;
      logic [15:0] even_exp;
      logic [15:0] odd_exp;
   } word_row_type;

   typedef struct {
      logic [11:0] index;
      logic [15:0] even;
      logic [15:0] odd;
   } sample_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [11:0] req_word_index = '0;
   logic        rsp_valid;
   logic [11:0] rsp_index_echo;
   logic [15:0] rsp_even_sample;
   logic [15:0] rsp_odd_sample;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Predictor copy of the registers.
   logic        mode_ramp;
   logic [15:0] amp_reg;
   logic [3:0]  plog_reg;

   sample_pair_type pending_pairs[$];
   int          mismatches = 0;
   int          pairs_seen = 0;
   int          words_sent = 0;
   int          cycles = 0;
   word_row_type rows[$];

   dac_waveform_pair_generator_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word_index(req_word_index), .rsp_valid(rsp_valid),
      .rsp_index_echo(rsp_index_echo), .rsp_even_sample(rsp_even_sample),
      .rsp_odd_sample(rsp_odd_sample), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Sine of r quarter-grid steps, Q18, Taylor series in Q30.
   function automatic logic [63:0] qsin(input logic [63:0] r);
      logic [63:0] x, x2, t, sub, s;
      x  = (r * 64'd1686629713 + 64'd1024) >> 11;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int j = 7; j >= 1; j--) begin
         sub = ((x2 * t) >> 30) / 64'((2 * j) * (2 * j + 1));
         t   = (sub >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - sub;
      end
      s = (((x * t) >> 30) + 64'd2048) >> 12;
      if (s > (64'd1 << 18)) s = 64'd1 << 18;
      return s;
   endfunction

   function automatic logic [15:0] point_sample(input logic [63:0] n, input int k);
      logic [63:0] m, p, q, r, y, v;
      m = n & ((64'd1 << k) - 1);
      if (mode_ramp) begin
         v = (m * amp_reg) >> k;
      end else begin
         p = m << (13 - k);
         q = (p >> 11) & 3;
         r = p & 2047;
         if (q[0]) r = 2048 - r;
         y = (q >= 2) ? (64'd1 << 18) - qsin(r) : (64'd1 << 18) + qsin(r);
         v = (y * amp_reg) >> 19;
      end
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic sample_pair_type predict_pair(input logic [11:0] w);
      sample_pair_type pr;
      int k;
      k = plog_reg;
      if (k < 2) k = 2;
      if (k > 13) k = 13;
      pr.index = w;
      pr.even  = point_sample({51'd0, w, 1'b0}, k);
      pr.odd   = point_sample({51'd0, w, 1'b1}, k);
      return pr;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("error: %s got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   // Result checking; the receiver never stalls.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected result index", rsp_index_echo, -1);
         end else begin
            sample_pair_type e;
            e = pending_pairs.pop_front();
            pairs_seen++;
            if (rsp_index_echo !== e.index) report_mismatch("index", rsp_index_echo, e.index);
            if (rsp_even_sample !== e.even) report_mismatch("even", rsp_even_sample, e.even);
            if (rsp_odd_sample !== e.odd) report_mismatch("odd", rsp_odd_sample, e.odd);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("timeout");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WAVE_MODE:   mode_ramp = val[0];
         CSR_AMPLITUDE:   amp_reg   = val;
         CSR_PERIOD_LOG2: plog_reg  = val[3:0];
         default: ;
      endcase
   endtask

   // One input transfer, with a random gap before it when asked.
   task automatic send_word(input logic [11:0] w, input bit gaps, input word_row_type row);
      int gap;
      sample_pair_type pr;
      gap = gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word_index <= w;
      do @(posedge clock); while (busy);
      pr = predict_pair(w);
      if (row.check) begin
         pr.even = row.even_exp;
         pr.odd  = row.odd_exp;
      end
      pending_pairs.push_back(pr);
      words_sent++;
   endtask

   task automatic run_random(input int count);
      word_row_type none;
      bit gaps;
      none.check = 1'b0;
      gaps = $urandom_range(0, 1);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) gaps = ~gaps;
         send_word($urandom_range(0, 4095), gaps, none);
      end
      start <= 1'b0;
   endtask

   initial begin
      word_row_type r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      mode_ramp = 1'b0;
      amp_reg   = AMPLITUDE_RESET;
      plog_reg  = PERIOD_RESET;

      // Directed table under reset settings: sine, amplitude 4096, 8192 points.
      r = '{12'd0, 1'b1, 16'd2048, 16'd2049};
      rows.push_back(r);
      r = '{12'd1024, 1'b1, 16'd4096, 16'd4096};
      rows.push_back(r);
      r = '{12'd2048, 1'b1, 16'd2048, 16'd2046};
      rows.push_back(r);
      r = '{12'd3072, 1'b1, 16'd0, 16'd0};
      rows.push_back(r);
      r = '{12'd4095, 1'b0, 16'd0, 16'd0};
      rows.push_back(r);
      r = '{12'd2047, 1'b0, 16'd0, 16'd0};
      rows.push_back(r);
      r = '{12'hAAA, 1'b0, 16'd0, 16'd0};
      rows.push_back(r);
      r = '{12'h555, 1'b0, 16'd0, 16'd0};
      rows.push_back(r);
      foreach (rows[i]) send_word(rows[i].word, 1'b0, rows[i]);
      start <= 1'b0;
      wait_drained();

      // Ramp, full amplitude, shortest period (out of range low, clamped to 2).
      csr_write(CSR_WAVE_MODE, 16'd1);
      csr_write(CSR_AMPLITUDE, 16'hFFFF);
      csr_write(CSR_PERIOD_LOG2, 16'd0);
      rows.delete();
      r = '{12'd0, 1'b1, 16'd0, 16'd16383};
      rows.push_back(r);
      r = '{12'd1, 1'b1, 16'd32767, 16'd49151};
      rows.push_back(r);
      r = '{12'd4095, 1'b1, 16'd32767, 16'd49151};
      rows.push_back(r);
      foreach (rows[i]) send_word(rows[i].word, 1'b1, rows[i]);
      start <= 1'b0;
      wait_drained();

      // Sine with amplitude zero, then period above range.
      csr_write(CSR_WAVE_MODE, 16'd0);
      csr_write(CSR_AMPLITUDE, 16'd0);
      csr_write(CSR_PERIOD_LOG2, 16'd15);
      run_random(10);
      wait_drained();

      // Random phases over random settings, extremes included.
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_WAVE_MODE, $urandom_range(0, 1));
         csr_write(CSR_AMPLITUDE, (ph == 0) ? 16'hFFFF : $urandom_range(0, 65535));
         csr_write(CSR_PERIOD_LOG2, (ph < 2) ? 16'd2 + 11 * ph : $urandom_range(0, 15));
         run_random(55);
         // The sender holds off here until every result is back.
         wait_drained();
      end

      $display("Sent %0d words over sine and ramp settings; %0d sample pairs checked.",
               words_sent, pairs_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
